// ----- src/pdsr_pkg.sv -----
`default_nettype none

package pdsr_pkg;

   parameter int ADC_BITS_DEF = 12;

   parameter int MUL_W = 17;
   parameter int ACC_W = 2 * MUL_W;
   parameter int CNT_W = $clog2(MUL_W);
   parameter int ROUND_SHIFT = 8;
   parameter int SUM_W = ACC_W - ROUND_SHIFT + 2;

   parameter int CSR_IDX_W = 3;
   parameter int CSR_DATA_W = 16;
   parameter int GAIN_W = 13;
   parameter int TARGET_W = 20;
   parameter int BAND_W = 30;
   parameter int TIME_W = 32;

   parameter logic [MUL_W-1:0] SAT_MAX = 17'h1FFFF;
   parameter logic [MUL_W-1:0] ROUND_BIAS = 17'd128;
   parameter logic signed [7:0] DRIVE_MIN = -8'sd127;
   parameter logic signed [7:0] DRIVE_MAX = 8'sd127;
   parameter logic signed [7:0] DRIVE_TARGET = -8'sd50;

   parameter logic [GAIN_W-1:0] VOLT_GAIN_RST = 13'd3789;
   parameter logic [CSR_DATA_W-1:0] VOLT_OFFSET_RST = 16'd922;
   parameter logic [GAIN_W-1:0] CURR_GAIN_RST = 13'd7398;
   parameter logic [CSR_DATA_W-1:0] CURR_OFFSET_RST = 16'd2718;
   parameter logic [CSR_DATA_W-1:0] RUN_DURATION_RST = 16'd0;

   parameter logic [CSR_IDX_W-1:0] CSR_VOLT_GAIN = 3'd0;
   parameter logic [CSR_IDX_W-1:0] CSR_VOLT_OFFSET = 3'd1;
   parameter logic [CSR_IDX_W-1:0] CSR_CURR_GAIN = 3'd2;
   parameter logic [CSR_IDX_W-1:0] CSR_CURR_OFFSET = 3'd3;
   parameter logic [CSR_IDX_W-1:0] CSR_RUN_DURATION = 3'd4;

   parameter logic [2:0] CMD_SAMPLE = 3'd0;
   parameter logic [2:0] CMD_START = 3'd1;
   parameter logic [2:0] CMD_STOP = 3'd2;
   parameter logic [2:0] CMD_TARGET = 3'd3;

   parameter logic [1:0] KIND_IDLE = 2'd0;
   parameter logic [1:0] KIND_RUN = 2'd1;
   parameter logic [1:0] KIND_FINISH = 2'd2;
   parameter logic [1:0] KIND_DRIVE = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_FIX  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PH_VOLT = 2'd0,
      PH_CURR = 2'd1,
      PH_POWR = 2'd2
   } phase_type;

   function automatic logic [MUL_W-1:0] scale_sat(input logic [ACC_W-1:0] prod,
                                                    input logic [CSR_DATA_W-1:0] offset);
      logic signed [SUM_W-1:0] sum;
      sum = $signed({2'b00, prod[ACC_W-1:ROUND_SHIFT]})
            + $signed({{(SUM_W-CSR_DATA_W){offset[CSR_DATA_W-1]}}, offset});
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed(SUM_W'(SAT_MAX))) begin
         return SAT_MAX;
      end
      return sum[MUL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/power_deadband_speed_regulator.sv -----
`default_nettype none

// Power regulator with a +-2% deadband. A sample transfer scales the voltage and
// current readings ((adc * gain + 128) >> 8 plus offset, saturated to 0..131071)
// and, while a run is active, steps the signed drive down or up by one against the
// power target. All three products go through one 17-bit shift-and-add multiplier
// that retires one multiplier bit per cycle, so a sample occupies the block from
// its transfer to its result; start, stop, set-target and other commands skip the
// multiplier and go straight to the emit state. The next item is taken in the cycle
// after the result is registered, even while that result is still stalled on the
// output; the item after it then waits in the emit state until the stalled result
// is taken.

module power_deadband_speed_regulator #(
   parameter int ADC_BITS = pdsr_pkg::ADC_BITS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [2:0]                           req_cmd,
   input  wire  [pdsr_pkg::TIME_W-1:0]          req_time_s,
   input  wire  [ADC_BITS-1:0]                  req_volt_adc,
   input  wire  [ADC_BITS-1:0]                  req_curr_adc,
   input  wire  [pdsr_pkg::TARGET_W-1:0]        req_target_mw,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [1:0]                           rsp_kind,
   output logic signed [7:0]                    rsp_drive,
   output logic [pdsr_pkg::MUL_W-1:0]           rsp_voltage_mv,
   output logic [pdsr_pkg::MUL_W-1:0]           rsp_current_ma,
   output logic [pdsr_pkg::TIME_W-1:0]          rsp_elapsed_s,
   input  wire                                  csr_write,
   input  wire  [pdsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [pdsr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int MUL_W = pdsr_pkg::MUL_W;
   localparam int ACC_W = pdsr_pkg::ACC_W;
   localparam int CNT_W = pdsr_pkg::CNT_W;
   localparam int TIME_W = pdsr_pkg::TIME_W;
   localparam int BAND_W = pdsr_pkg::BAND_W;
   localparam int TARGET_W = pdsr_pkg::TARGET_W;
   localparam int GAIN_W = pdsr_pkg::GAIN_W;
   localparam int CSR_DATA_W = pdsr_pkg::CSR_DATA_W;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);
   localparam logic [ACC_W-1:0] ACC_ROUND = {pdsr_pkg::ROUND_BIAS, MUL_W'(0)};

   pdsr_pkg::state_type state_ff, state_in;
   pdsr_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [MUL_W-1:0] mcand_ff, mcand_in;
   logic [MUL_W-1:0] mplier_ff, mplier_in;

   logic [2:0] cmd_ff, cmd_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [ADC_BITS-1:0] cadc_ff, cadc_in;
   logic [MUL_W-1:0] mv_ff, mv_in;
   logic [MUL_W-1:0] ma_ff, ma_in;

   logic running_ff, running_in;
   logic signed [7:0] speed_ff, speed_in;
   logic [BAND_W-1:0] hi_ff, hi_in;
   logic [BAND_W-1:0] lo_ff, lo_in;
   logic [TIME_W-1:0] run_start_ff, run_start_in;
   logic [TIME_W-1:0] last_report_ff, last_report_in;

   logic [GAIN_W-1:0] volt_gain_ff, volt_gain_in;
   logic [CSR_DATA_W-1:0] volt_offset_ff, volt_offset_in;
   logic [GAIN_W-1:0] curr_gain_ff, curr_gain_in;
   logic [CSR_DATA_W-1:0] curr_offset_ff, curr_offset_in;
   logic [CSR_DATA_W-1:0] run_duration_ff, run_duration_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic signed [7:0] rsp_drive_ff, rsp_drive_in;
   logic [MUL_W-1:0] rsp_mv_ff, rsp_mv_in;
   logic [MUL_W-1:0] rsp_ma_ff, rsp_ma_in;
   logic [TIME_W-1:0] rsp_elapsed_ff, rsp_elapsed_in;

   logic [MUL_W:0] step_sum;
   logic [MUL_W-1:0] scaled;
   logic fire;
   logic [TIME_W-1:0] elapsed;
   logic [BAND_W-1:0] tgt_ext;
   logic signed [8:0] speed_step;

   assign req_stall = (state_ff != pdsr_pkg::ST_IDLE);
   assign fire = !rsp_valid_ff || !rsp_stall;
   assign step_sum = {1'b0, acc_ff[ACC_W-1:MUL_W]}
                     + (mplier_ff[0] ? {1'b0, mcand_ff} : '0);
   assign scaled = pdsr_pkg::scale_sat(acc_ff,
                      (phase_ff == pdsr_pkg::PH_VOLT) ? volt_offset_ff : curr_offset_ff);
   assign elapsed = time_ff - run_start_ff;
   assign tgt_ext = BAND_W'(target_ff);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cmd_in = cmd_ff;
      time_in = time_ff;
      target_in = target_ff;
      cadc_in = cadc_ff;
      mv_in = mv_ff;
      ma_in = ma_ff;
      running_in = running_ff;
      speed_in = speed_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      run_start_in = run_start_ff;
      last_report_in = last_report_ff;
      volt_gain_in = volt_gain_ff;
      volt_offset_in = volt_offset_ff;
      curr_gain_in = curr_gain_ff;
      curr_offset_in = curr_offset_ff;
      run_duration_in = run_duration_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_mv_in = rsp_mv_ff;
      rsp_ma_in = rsp_ma_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      speed_step = {speed_ff[7], speed_ff};

      if (csr_write) begin
         unique case (csr_index)
            pdsr_pkg::CSR_VOLT_GAIN:    volt_gain_in = csr_data[GAIN_W-1:0];
            pdsr_pkg::CSR_VOLT_OFFSET:  volt_offset_in = csr_data;
            pdsr_pkg::CSR_CURR_GAIN:    curr_gain_in = csr_data[GAIN_W-1:0];
            pdsr_pkg::CSR_CURR_OFFSET:  curr_offset_in = csr_data;
            pdsr_pkg::CSR_RUN_DURATION: run_duration_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         pdsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               time_in = req_time_s;
               target_in = req_target_mw;
               cadc_in = req_curr_adc;
               mcand_in = MUL_W'(volt_gain_ff);
               mplier_in = MUL_W'(req_volt_adc);
               acc_in = ACC_ROUND;
               cnt_in = '0;
               phase_in = pdsr_pkg::PH_VOLT;
               state_in = (req_cmd == pdsr_pkg::CMD_SAMPLE) ? pdsr_pkg::ST_MUL
                                                            : pdsr_pkg::ST_EMIT;
            end
         end
         pdsr_pkg::ST_MUL: begin
            acc_in = {step_sum, acc_ff[MUL_W-1:1]};
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = pdsr_pkg::ST_FIX;
            end
         end
         pdsr_pkg::ST_FIX: begin
            cnt_in = '0;
            case (phase_ff)
               pdsr_pkg::PH_VOLT: begin
                  mv_in = scaled;
                  mcand_in = MUL_W'(curr_gain_ff);
                  mplier_in = MUL_W'(cadc_ff);
                  acc_in = ACC_ROUND;
                  phase_in = pdsr_pkg::PH_CURR;
                  state_in = pdsr_pkg::ST_MUL;
               end
               pdsr_pkg::PH_CURR: begin
                  ma_in = scaled;
                  mcand_in = mv_ff;
                  mplier_in = scaled;
                  acc_in = '0;
                  phase_in = pdsr_pkg::PH_POWR;
                  state_in = pdsr_pkg::ST_MUL;
               end
               default: begin
                  state_in = pdsr_pkg::ST_EMIT;
               end
            endcase
         end
         pdsr_pkg::ST_EMIT: begin
            if (fire) begin
               state_in = pdsr_pkg::ST_IDLE;
               rsp_mv_in = '0;
               rsp_ma_in = '0;
               rsp_elapsed_in = '0;
               rsp_kind_in = pdsr_pkg::KIND_DRIVE;
               case (cmd_ff)
                  pdsr_pkg::CMD_START: begin
                     running_in = 1'b1;
                     run_start_in = time_ff;
                  end
                  pdsr_pkg::CMD_STOP: begin
                     speed_in = pdsr_pkg::DRIVE_MIN;
                     running_in = 1'b0;
                     rsp_valid_in = 1'b1;
                     rsp_drive_in = pdsr_pkg::DRIVE_MIN;
                  end
                  pdsr_pkg::CMD_TARGET: begin
                     hi_in = (tgt_ext << 10) - (tgt_ext << 2);
                     lo_in = (tgt_ext << 10) - (tgt_ext << 5) - (tgt_ext << 3)
                             - (tgt_ext << 2);
                     speed_in = pdsr_pkg::DRIVE_TARGET;
                     run_start_in = time_ff;
                     rsp_valid_in = 1'b1;
                     rsp_drive_in = pdsr_pkg::DRIVE_TARGET;
                  end
                  pdsr_pkg::CMD_SAMPLE: begin
                     rsp_mv_in = mv_ff;
                     rsp_ma_in = ma_ff;
                     if (!running_ff) begin
                        if (time_ff != last_report_ff) begin
                           last_report_in = time_ff;
                           rsp_valid_in = 1'b1;
                           rsp_kind_in = pdsr_pkg::KIND_IDLE;
                           rsp_drive_in = speed_ff;
                        end
                     end else if (elapsed > TIME_W'(run_duration_ff)) begin
                        running_in = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_kind_in = pdsr_pkg::KIND_FINISH;
                        rsp_drive_in = pdsr_pkg::DRIVE_MIN;
                        rsp_elapsed_in = elapsed;
                     end else begin
                        if (acc_ff > ACC_W'(hi_ff)) begin
                           speed_step = {speed_ff[7], speed_ff} - 9'sd1;
                           if (speed_step < 9'(pdsr_pkg::DRIVE_MIN)) begin
                              speed_step = 9'(pdsr_pkg::DRIVE_MIN);
                           end
                        end else if (acc_ff < ACC_W'(lo_ff)) begin
                           speed_step = {speed_ff[7], speed_ff} + 9'sd1;
                        end
                        if (speed_step > 9'(pdsr_pkg::DRIVE_MAX)) begin
                           speed_step = 9'(pdsr_pkg::DRIVE_MAX);
                        end
                        speed_in = speed_step[7:0];
                        rsp_valid_in = 1'b1;
                        rsp_kind_in = pdsr_pkg::KIND_RUN;
                        rsp_drive_in = speed_step[7:0];
                        rsp_elapsed_in = elapsed;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            state_in = pdsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pdsr_pkg::ST_IDLE;
         running_ff <= 1'b0;
         speed_ff <= '0;
         hi_ff <= '0;
         lo_ff <= '0;
         run_start_ff <= '0;
         last_report_ff <= '0;
         volt_gain_ff <= pdsr_pkg::VOLT_GAIN_RST;
         volt_offset_ff <= pdsr_pkg::VOLT_OFFSET_RST;
         curr_gain_ff <= pdsr_pkg::CURR_GAIN_RST;
         curr_offset_ff <= pdsr_pkg::CURR_OFFSET_RST;
         run_duration_ff <= pdsr_pkg::RUN_DURATION_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         running_ff <= running_in;
         speed_ff <= speed_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         run_start_ff <= run_start_in;
         last_report_ff <= last_report_in;
         volt_gain_ff <= volt_gain_in;
         volt_offset_ff <= volt_offset_in;
         curr_gain_ff <= curr_gain_in;
         curr_offset_ff <= curr_offset_in;
         run_duration_ff <= run_duration_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      cmd_ff <= cmd_in;
      time_ff <= time_in;
      target_ff <= target_in;
      cadc_ff <= cadc_in;
      mv_ff <= mv_in;
      ma_ff <= ma_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_mv_ff <= rsp_mv_in;
      rsp_ma_ff <= rsp_ma_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_drive = rsp_drive_ff;
   assign rsp_voltage_mv = rsp_mv_ff;
   assign rsp_current_ma = rsp_ma_ff;
   assign rsp_elapsed_s = rsp_elapsed_ff;

endmodule

`default_nettype wire

// ----- src/pdsr_checker.sv -----
`default_nettype none

module pdsr_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire [1:0]                        rsp_kind,
   input wire signed [7:0]                 rsp_drive,
   input wire [pdsr_pkg::MUL_W-1:0]        rsp_voltage_mv,
   input wire [pdsr_pkg::MUL_W-1:0]        rsp_current_ma,
   input wire [pdsr_pkg::TIME_W-1:0]       rsp_elapsed_s
);

   // A stalled result transfer stays valid and keeps its kind, drive and elapsed time until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_drive)
                                 && $stable(rsp_elapsed_s))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive != -8'sd128)
      else $error("drive out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pdsr_pkg::KIND_DRIVE |->
         (rsp_drive == pdsr_pkg::DRIVE_MIN || rsp_drive == pdsr_pkg::DRIVE_TARGET)
         && rsp_voltage_mv == '0 && rsp_current_ma == '0 && rsp_elapsed_s == '0)
      else $error("bad drive change result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pdsr_pkg::KIND_FINISH |-> rsp_drive == pdsr_pkg::DRIVE_MIN)
      else $error("run finish without full reverse drive");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pdsr_pkg::KIND_IDLE |-> rsp_elapsed_s == '0)
      else $error("idle telemetry with elapsed time");

endmodule

bind power_deadband_speed_regulator pdsr_checker u_pdsr_checker (.*);

`default_nettype wire
